FILE: design/swm_pkg.sv
// Shared constants and controller/datapath interface types for the
// sliding window median core. No dependencies.
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_BITS    = 7;
  localparam int RESET_SIZE  = 3;
  localparam int WIN_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef struct packed {
    logic                accept;
    logic [WIN_BITS-1:0] rd_off;
    logic                cand_load;
    logic                cnt_clear;
    logic                cnt_en;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] win_size;
    logic                emit;
    logic                found;
    logic                out_free;
  } stat_t;

endpackage

FILE: design/sliding_window_median_core.sv
// Sliding window median core: top level joining the sequencer and the datapath.
// Depends on swm_pkg, swm_ctrl and swm_datapath.
//
// Running lower median over the last window_size samples (1..64, 0 reads as 1,
// larger values as 64). A word with stream_start set empties the window first;
// no result appears until window_size samples have arrived since the last
// start. One sample is taken in a cycle when idle; a sample that yields a
// result then occupies the block while candidates are tried in turn until
// the median is found. Each candidate is compared against every stored
// sample of the window over the single read port of the sample ring, one
// stored sample a cycle per candidate. A finished median waits in the
// output register while the next sample is accepted.
module sliding_window_median_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [31:0] sample
  input  logic                         in_tuser,   // [0] stream_start
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata   // [31:0] median
);

  swm_pkg::cmd_t  cmd;
  swm_pkg::stat_t stat;
  logic signed [swm_pkg::SAMPLE_BITS-1:0] median;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata),
    .in_start   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_median (median)
  );

  assign out_tdata = median;

endmodule

FILE: design/swm_ctrl.sv
// Sequencer for the median search: accepts a word, then walks each
// candidate over the window. Depends on swm_pkg.
module swm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  swm_pkg::stat_t stat,
  output swm_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAND,
    S_SCAN,
    S_CHECK
  } state_t;

  state_t                       state_r, state_nxt;
  logic [swm_pkg::WIN_BITS-1:0] cand_r, cand_nxt;
  logic [swm_pkg::WIN_BITS-1:0] idx_r, idx_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid && stat.emit) begin
          cand_nxt  = '0;
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        cmd.rd_off    = cand_r;
        cmd.cnt_clear = 1'b1;
        idx_nxt       = '0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_off    = (idx_r == stat.win_size) ? '0 : idx_r;
        cmd.cand_load = (idx_r == '0);
        cmd.cnt_en    = (idx_r != '0);
        if (idx_r == stat.win_size) begin
          state_nxt = S_CHECK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.found) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cand_nxt  = cand_r + 1'b1;
          state_nxt = S_CAND;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cand_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cand_r  <= cand_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: design/swm_datapath.sv
// Sample ring memory, window bookkeeping, rank counters and output
// register for the median core. Depends on swm_pkg.
module swm_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  logic signed [swm_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_start,
  input  swm_pkg::cmd_t                       cmd,
  output swm_pkg::stat_t                      stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [swm_pkg::SAMPLE_BITS-1:0] out_median
);

  localparam int SUMW = $clog2(2 * swm_pkg::WINDOW_MAX + 1);

  logic signed [swm_pkg::SAMPLE_BITS-1:0] ring_mem [swm_pkg::WINDOW_MAX];
  logic signed [swm_pkg::SAMPLE_BITS-1:0] rdata_r;
  logic signed [swm_pkg::SAMPLE_BITS-1:0] cand_val_r;
  logic signed [swm_pkg::SAMPLE_BITS-1:0] median_r;
  logic [swm_pkg::CFG_BITS-1:0]           size_cfg_r;
  logic [swm_pkg::ADDR_BITS-1:0]          head_r, head_nxt, wr_addr;
  logic [swm_pkg::WIN_BITS-1:0]           fill_r, fill_nxt;
  logic [swm_pkg::WIN_BITS-1:0]           lt_r, le_r, win_k, rank;
  logic [SUMW-1:0]                        addr_sum;
  logic [swm_pkg::ADDR_BITS-1:0]          rd_addr;
  logic                                   out_valid_r;

  always_comb begin
    if (size_cfg_r == '0) begin
      win_k = swm_pkg::WIN_BITS'(1);
    end else if (int'(size_cfg_r) > swm_pkg::WINDOW_MAX) begin
      win_k = swm_pkg::WIN_BITS'(swm_pkg::WINDOW_MAX);
    end else begin
      win_k = swm_pkg::WIN_BITS'(int'(size_cfg_r));
    end
  end

  assign rank = (win_k - 1'b1) >> 1;

  always_comb begin
    wr_addr = in_start ? '0 : head_r;
    if (int'(wr_addr) == swm_pkg::WINDOW_MAX - 1) begin
      head_nxt = '0;
    end else begin
      head_nxt = wr_addr + 1'b1;
    end
    if (in_start) begin
      fill_nxt = swm_pkg::WIN_BITS'(1);
    end else if (int'(fill_r) == swm_pkg::WINDOW_MAX) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  // newest sample sits at head - 1; offset walks back in arrival order
  always_comb begin
    addr_sum = SUMW'(head_r) + SUMW'(swm_pkg::WINDOW_MAX - 1) - SUMW'(cmd.rd_off);
    if (int'(addr_sum) >= swm_pkg::WINDOW_MAX) begin
      addr_sum = addr_sum - SUMW'(swm_pkg::WINDOW_MAX);
    end
    rd_addr = addr_sum[swm_pkg::ADDR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[wr_addr] <= in_sample;
    end
    rdata_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r  <= swm_pkg::CFG_BITS'(swm_pkg::RESET_SIZE);
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_cfg_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      cand_val_r <= rdata_r;
    end
    if (cmd.cnt_clear) begin
      lt_r <= '0;
      le_r <= '0;
    end else if (cmd.cnt_en) begin
      if (rdata_r < cand_val_r) begin
        lt_r <= lt_r + 1'b1;
      end
      if (rdata_r <= cand_val_r) begin
        le_r <= le_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      median_r <= cand_val_r;
    end
  end

  always_comb begin
    stat.win_size = win_k;
    stat.emit     = (fill_nxt >= win_k);
    stat.found    = (lt_r <= rank) && (le_r > rank);
    stat.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_median = median_r;

endmodule
